// ----- rtl/lru_free_list_with_pins_top_defines.svh -----
// ----------------------------------------------------------------------------
// lru_free_list_with_pins_top_defines: assertion macros
// Shared property forms for the free list checks, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef LRU_FREE_LIST_WITH_PINS_TOP_DEFINES_SVH
`define LRU_FREE_LIST_WITH_PINS_TOP_DEFINES_SVH

// same-cycle implication
`define LFL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfl_pkg: free list package
// Sizes, codes, control word layout and the microcode program.
// ----------------------------------------------------------------------------
package lfl_pkg;

    localparam int NUM_BUFFERS = 256;
    localparam int PIN_BITS    = 16;
    localparam int IDX_W       = $clog2(NUM_BUFFERS + 1);
    localparam int BUF_W       = $clog2(NUM_BUFFERS);
    localparam int ID_W        = 8;
    localparam int CNT_OUT_W   = 16;
    localparam int ACT_W       = 2;
    localparam int STEP_W      = 5;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [BUF_W-1:0]     buf_t;
    typedef logic [PIN_BITS-1:0]  pin_t;
    typedef logic [ID_W-1:0]      id_t;
    typedef logic [CNT_OUT_W-1:0] cnt_out_t;
    typedef logic [STEP_W-1:0]    step_t;

    localparam idx_t HEAD_IDX = idx_t'(NUM_BUFFERS);
    localparam pin_t PIN_MAX  = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_PIN   = 2'd0,
        ACT_UNPIN = 2'd1,
        ACT_TAKE  = 2'd2
    } action_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_UNPIN_ERR = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_e;

    typedef enum logic [1:0] {LT_NONE, LT_NP, LT_FIRST} latch_e;

    typedef enum logic [2:0] {
        C_NONE, C_PIN_OVF, C_PIN_KEEP, C_UNPIN_ZERO, C_UNPIN_KEEP, C_EMPTY
    } cond_e;

    // next link writes: next[p]=n, next[b]=head, next[p]=b
    typedef enum logic [1:0] {NW_NONE, NW_P_N, NW_B_H, NW_P_B} nwr_e;
    // prev link writes: prev[n]=p, prev[b]=head, prev[b]=p, prev[head]=b
    typedef enum logic [2:0] {PW_NONE, PW_N_P, PW_B_H, PW_B_P, PW_H_B} pwr_e;
    typedef enum logic [1:0] {CW_NONE, CW_INC, CW_DEC} cwr_e;
    typedef enum logic [1:0] {FW_NONE, FW_CLR, FW_SET} fwr_e;
    typedef enum logic [1:0] {CS_ZERO, CS_REG, CS_INC, CS_DEC} csel_e;

    typedef struct packed {
        logic    nrd_head;
        logic    prd_head;
        latch_e  latch;
        cond_e   br0_cond;
        step_t   br0_tgt;
        cond_e   br1_cond;
        step_t   br1_tgt;
        nwr_e    nwr;
        pwr_e    pwr;
        cwr_e    cwr;
        fwr_e    fwr;
        logic    done;
        status_e status;
        logic    vsel;
        csel_e   csel;
    } cw_t;

    typedef struct packed {
        logic pin_ovf;
        logic pin_keep;
        logic unpin_zero;
        logic unpin_keep;
        logic empty;
    } flags_t;

    typedef struct packed {
        id_t      victim;
        status_e  status;
        cnt_out_t count;
    } res_t;

    // program addresses
    localparam step_t S_P0      = 5'd0;
    localparam step_t S_P1      = 5'd1;
    localparam step_t S_P2      = 5'd2;
    localparam step_t S_P3      = 5'd3;
    localparam step_t S_PIN_INC = 5'd4;
    localparam step_t S_U0      = 5'd5;
    localparam step_t S_U1      = 5'd6;
    localparam step_t S_U2      = 5'd7;
    localparam step_t S_U3      = 5'd8;
    localparam step_t S_OVF     = 5'd9;
    localparam step_t S_ERR     = 5'd10;
    localparam step_t S_DEC     = 5'd11;
    localparam step_t S_T0      = 5'd12;
    localparam step_t S_T1      = 5'd13;
    localparam step_t S_T2      = 5'd14;
    localparam step_t S_T3      = 5'd15;
    localparam step_t S_T4      = 5'd16;
    localparam step_t S_T5      = 5'd17;
    localparam step_t S_EMPTY   = 5'd18;
    localparam step_t S_NOP     = 5'd19;

    function automatic cw_t ucode(step_t s);
        cw_t w;
        w = '0;
        case (s)
            // pin: read entry, then unlink if free and unpinned
            S_P0: begin
            end
            S_P1: begin
                w.latch    = LT_NP;
                w.br0_cond = C_PIN_OVF;
                w.br0_tgt  = S_OVF;
                w.br1_cond = C_PIN_KEEP;
                w.br1_tgt  = S_PIN_INC;
            end
            S_P2: begin
                w.nwr = NW_P_N;
                w.pwr = PW_N_P;
            end
            S_P3: begin
                w.nwr  = NW_B_H;
                w.pwr  = PW_B_H;
                w.fwr  = FW_CLR;
                w.cwr  = CW_INC;
                w.done = 1'b1;
                w.csel = CS_INC;
            end
            S_PIN_INC: begin
                w.cwr  = CW_INC;
                w.done = 1'b1;
                w.csel = CS_INC;
            end
            // unpin: read tail and count, append at tail on reaching zero
            S_U0: begin
                w.prd_head = 1'b1;
            end
            S_U1: begin
                w.latch    = LT_NP;
                w.br0_cond = C_UNPIN_ZERO;
                w.br0_tgt  = S_ERR;
                w.br1_cond = C_UNPIN_KEEP;
                w.br1_tgt  = S_DEC;
            end
            S_U2: begin
                w.pwr = PW_B_P;
                w.nwr = NW_B_H;
            end
            S_U3: begin
                w.pwr  = PW_H_B;
                w.nwr  = NW_P_B;
                w.cwr  = CW_DEC;
                w.fwr  = FW_SET;
                w.done = 1'b1;
                w.csel = CS_DEC;
            end
            S_OVF: begin
                w.done   = 1'b1;
                w.status = ST_OVERFLOW;
                w.csel   = CS_REG;
            end
            S_ERR: begin
                w.done   = 1'b1;
                w.status = ST_UNPIN_ERR;
            end
            S_DEC: begin
                w.cwr  = CW_DEC;
                w.done = 1'b1;
                w.csel = CS_DEC;
            end
            // take: fetch first entry after head, then unlink it
            S_T0: begin
                w.nrd_head = 1'b1;
            end
            S_T1: begin
                w.latch    = LT_FIRST;
                w.br0_cond = C_EMPTY;
                w.br0_tgt  = S_EMPTY;
            end
            S_T2: begin
            end
            S_T3: begin
                w.latch = LT_NP;
            end
            S_T4: begin
                w.nwr = NW_P_N;
                w.pwr = PW_N_P;
            end
            S_T5: begin
                w.nwr  = NW_B_H;
                w.pwr  = PW_B_H;
                w.fwr  = FW_CLR;
                w.done = 1'b1;
                w.vsel = 1'b1;
                w.csel = CS_REG;
            end
            S_EMPTY: begin
                w.done   = 1'b1;
                w.status = ST_EMPTY;
            end
            S_NOP: begin
                w.done = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic idx_t clamp_idx(idx_t i);
        return (i <= HEAD_IDX) ? i : HEAD_IDX;
    endfunction

    // reset order: head, 1, 2, .., N-1, 0, head
    function automatic idx_t init_next(idx_t i);
        idx_t r;
        if (i == HEAD_IDX) begin
            r = idx_t'(1);
        end else if (i == '0) begin
            r = HEAD_IDX;
        end else if (i == idx_t'(NUM_BUFFERS - 1)) begin
            r = '0;
        end else begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    function automatic idx_t init_prev(idx_t i);
        idx_t r;
        if (i == idx_t'(1)) begin
            r = HEAD_IDX;
        end else if (i == HEAD_IDX) begin
            r = '0;
        end else if (i == '0) begin
            r = idx_t'(NUM_BUFFERS - 1);
        end else begin
            r = i - idx_t'(1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/lru_free_list_with_pins_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_free_list_with_pins_top: LRU free list with pin counts
// Buffer replacement list driven by a microcoded sequencer over link memories.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_      | in  | s_valid / s_ready   | s_action, s_buffer_id
//  m_      | out | m_valid / m_ready   | m_victim_id, m_status, m_pin_count
//
//  One request runs at a time: s_ready stays low from accept until the
//  program step that loads the result fires. The program steps over the
//  link memories, each with one registered read port and one write port.
//  After reset an init sweep loads the list; s_ready stays low.
//  A full result register holds the last program step until m_ready.
// ----------------------------------------------------------------------------
`include "lru_free_list_with_pins_top_defines.svh"

module lru_free_list_with_pins_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_buffer_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_victim_id,
    output logic [1:0]  m_status,
    output logic [15:0] m_pin_count
);

    logic            s_accept;
    logic            id_ok;
    lfl_pkg::step_t  entry;
    lfl_pkg::flags_t flags;
    lfl_pkg::cw_t    cw;
    lfl_pkg::res_t   res;
    logic            fire, seq_busy, clr_busy, hold, out_load;

    logic            m_valid_reg, m_valid_next;
    lfl_pkg::res_t   m_res_reg;

    assign s_ready  = !seq_busy && !clr_busy;
    assign s_accept = s_valid && s_ready;
    assign id_ok    = (lfl_pkg::idx_t'(s_buffer_id) < lfl_pkg::HEAD_IDX);

    always_comb begin
        case (s_action)
            lfl_pkg::ACT_PIN:   entry = id_ok ? lfl_pkg::S_P0 : lfl_pkg::S_NOP;
            lfl_pkg::ACT_UNPIN: entry = id_ok ? lfl_pkg::S_U0 : lfl_pkg::S_NOP;
            lfl_pkg::ACT_TAKE:  entry = lfl_pkg::S_T0;
            default:            entry = lfl_pkg::S_NOP;
        endcase
    end

    assign hold     = m_valid_reg && !m_ready;
    assign out_load = fire && cw.done;

    lfl_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .entry   (entry),
        .flags   (flags),
        .hold    (hold),
        .cw      (cw),
        .fire    (fire),
        .busy    (seq_busy)
    );

    lfl_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cw       (cw),
        .fire     (fire),
        .start    (s_accept),
        .start_id (s_buffer_id),
        .flags    (flags),
        .res      (res),
        .clr_busy (clr_busy)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_victim_id = m_res_reg.victim;
    assign m_status    = m_res_reg.status;
    assign m_pin_count = m_res_reg.count;

    `LFL_ASSERT_IMPL(a_no_run_in_sweep, clr_busy, !seq_busy, "program ran during init sweep")
    `LFL_ASSERT_NEXT(a_request_starts, s_accept, seq_busy, "accepted request did not start")
    `LFL_ASSERT_IMPL(a_no_overrun, out_load, !m_valid_reg || m_ready, "result overwritten")

endmodule

// ----- rtl/lfl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfl_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lfl_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/lfl_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfl_useq: microcode sequencer
// Step counter over the control program with two-way conditional jumps.
// ----------------------------------------------------------------------------
module lfl_useq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  lfl_pkg::step_t  entry,
    input  lfl_pkg::flags_t flags,
    input  logic            hold,
    output lfl_pkg::cw_t    cw,
    output logic            fire,
    output logic            busy
);

    logic           active_reg, active_next;
    lfl_pkg::step_t step_reg, step_next;

    function automatic logic cond_true(lfl_pkg::cond_e c, lfl_pkg::flags_t f);
        logic r;
        case (c)
            lfl_pkg::C_PIN_OVF:    r = f.pin_ovf;
            lfl_pkg::C_PIN_KEEP:   r = f.pin_keep;
            lfl_pkg::C_UNPIN_ZERO: r = f.unpin_zero;
            lfl_pkg::C_UNPIN_KEEP: r = f.unpin_keep;
            lfl_pkg::C_EMPTY:      r = f.empty;
            default:               r = 1'b0;
        endcase
        return r;
    endfunction

    assign cw   = active_reg ? lfl_pkg::ucode(step_reg) : '0;
    // stall the final step while the result register is still full
    assign fire = active_reg && !(cw.done && hold);
    assign busy = active_reg;

    always_comb begin
        active_next = active_reg;
        step_next   = step_reg;
        if (start) begin
            active_next = 1'b1;
            step_next   = entry;
        end else if (fire) begin
            if (cw.done) begin
                active_next = 1'b0;
            end else if (cond_true(cw.br0_cond, flags)) begin
                step_next = cw.br0_tgt;
            end else if (cond_true(cw.br1_cond, flags)) begin
                step_next = cw.br1_tgt;
            end else begin
                step_next = step_reg + lfl_pkg::step_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end else begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

endmodule

// ----- rtl/lfl_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfl_dpath: free list datapath
// Link, count and free-mark memories, work registers and the init sweep.
// ----------------------------------------------------------------------------
module lfl_dpath (
    input  logic            aclk,
    input  logic            aresetn,
    input  lfl_pkg::cw_t    cw,
    input  logic            fire,
    input  logic            start,
    input  lfl_pkg::id_t    start_id,
    output lfl_pkg::flags_t flags,
    output lfl_pkg::res_t   res,
    output logic            clr_busy
);

    lfl_pkg::idx_t b_reg, n_reg, p_reg;
    lfl_pkg::pin_t cnt_reg;

    logic          clr_busy_reg, clr_busy_next;
    lfl_pkg::idx_t clr_idx_reg, clr_idx_next;

    logic          nxt_we, prv_we, cnt_we, frm_we;
    lfl_pkg::idx_t nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
    lfl_pkg::idx_t nxt_raddr, prv_raddr;
    lfl_pkg::buf_t cnt_waddr;
    lfl_pkg::pin_t cnt_wdata;
    logic          frm_wdata;

    lfl_pkg::idx_t nxt_rd, prv_rd, next_c, prev_c;
    lfl_pkg::pin_t cnt_rd;
    logic          free_rd;

    lfl_pkg::pin_t cnt_inc, cnt_dec;

    assign nxt_raddr = cw.nrd_head ? lfl_pkg::HEAD_IDX : b_reg;
    assign prv_raddr = cw.prd_head ? lfl_pkg::HEAD_IDX : b_reg;

    lfl_ram #(.DEPTH(lfl_pkg::NUM_BUFFERS + 1), .WIDTH(lfl_pkg::IDX_W)) u_next (
        .aclk    (aclk),
        .we      (nxt_we),
        .waddr   (nxt_waddr),
        .wdata   (nxt_wdata),
        .raddr   (nxt_raddr),
        .rd_data (nxt_rd)
    );

    lfl_ram #(.DEPTH(lfl_pkg::NUM_BUFFERS + 1), .WIDTH(lfl_pkg::IDX_W)) u_prev (
        .aclk    (aclk),
        .we      (prv_we),
        .waddr   (prv_waddr),
        .wdata   (prv_wdata),
        .raddr   (prv_raddr),
        .rd_data (prv_rd)
    );

    lfl_ram #(.DEPTH(lfl_pkg::NUM_BUFFERS), .WIDTH(lfl_pkg::PIN_BITS)) u_count (
        .aclk    (aclk),
        .we      (cnt_we),
        .waddr   (cnt_waddr),
        .wdata   (cnt_wdata),
        .raddr   (b_reg[lfl_pkg::BUF_W-1:0]),
        .rd_data (cnt_rd)
    );

    lfl_ram #(.DEPTH(lfl_pkg::NUM_BUFFERS), .WIDTH(1)) u_free (
        .aclk    (aclk),
        .we      (frm_we),
        .waddr   (cnt_waddr),
        .wdata   (frm_wdata),
        .raddr   (b_reg[lfl_pkg::BUF_W-1:0]),
        .rd_data (free_rd)
    );

    assign next_c  = lfl_pkg::clamp_idx(nxt_rd);
    assign prev_c  = lfl_pkg::clamp_idx(prv_rd);
    assign cnt_inc = cnt_reg + lfl_pkg::pin_t'(1);
    assign cnt_dec = cnt_reg - lfl_pkg::pin_t'(1);

    always_comb begin
        flags.pin_ovf    = (cnt_rd == lfl_pkg::PIN_MAX);
        flags.pin_keep   = !((cnt_rd == '0) && free_rd);
        flags.unpin_zero = (cnt_rd == '0);
        flags.unpin_keep = (cnt_rd != lfl_pkg::pin_t'(1));
        flags.empty      = (next_c == lfl_pkg::HEAD_IDX);
    end

    always_comb begin
        res.victim = cw.vsel ? lfl_pkg::id_t'(b_reg) : '0;
        res.status = cw.status;
        case (cw.csel)
            lfl_pkg::CS_REG: res.count = lfl_pkg::cnt_out_t'(cnt_reg);
            lfl_pkg::CS_INC: res.count = lfl_pkg::cnt_out_t'(cnt_inc);
            lfl_pkg::CS_DEC: res.count = lfl_pkg::cnt_out_t'(cnt_dec);
            default:         res.count = '0;
        endcase
    end

    always_comb begin
        nxt_we    = 1'b0;
        nxt_waddr = b_reg;
        nxt_wdata = lfl_pkg::HEAD_IDX;
        prv_we    = 1'b0;
        prv_waddr = b_reg;
        prv_wdata = lfl_pkg::HEAD_IDX;
        cnt_we    = 1'b0;
        cnt_waddr = b_reg[lfl_pkg::BUF_W-1:0];
        cnt_wdata = cnt_inc;
        frm_we    = 1'b0;
        frm_wdata = 1'b0;
        if (clr_busy_reg) begin
            // load the reset list order, zero counts, mark all free
            nxt_we    = 1'b1;
            nxt_waddr = clr_idx_reg;
            nxt_wdata = lfl_pkg::init_next(clr_idx_reg);
            prv_we    = 1'b1;
            prv_waddr = clr_idx_reg;
            prv_wdata = lfl_pkg::init_prev(clr_idx_reg);
            cnt_we    = (clr_idx_reg != lfl_pkg::HEAD_IDX);
            cnt_waddr = clr_idx_reg[lfl_pkg::BUF_W-1:0];
            cnt_wdata = '0;
            frm_we    = (clr_idx_reg != lfl_pkg::HEAD_IDX);
            frm_wdata = 1'b1;
        end else if (fire) begin
            case (cw.nwr)
                lfl_pkg::NW_P_N: begin
                    nxt_we    = 1'b1;
                    nxt_waddr = p_reg;
                    nxt_wdata = n_reg;
                end
                lfl_pkg::NW_B_H: begin
                    nxt_we    = 1'b1;
                    nxt_waddr = b_reg;
                    nxt_wdata = lfl_pkg::HEAD_IDX;
                end
                lfl_pkg::NW_P_B: begin
                    nxt_we    = 1'b1;
                    nxt_waddr = p_reg;
                    nxt_wdata = b_reg;
                end
                default: begin
                end
            endcase
            case (cw.pwr)
                lfl_pkg::PW_N_P: begin
                    prv_we    = 1'b1;
                    prv_waddr = n_reg;
                    prv_wdata = p_reg;
                end
                lfl_pkg::PW_B_H: begin
                    prv_we    = 1'b1;
                    prv_waddr = b_reg;
                    prv_wdata = lfl_pkg::HEAD_IDX;
                end
                lfl_pkg::PW_B_P: begin
                    prv_we    = 1'b1;
                    prv_waddr = b_reg;
                    prv_wdata = p_reg;
                end
                lfl_pkg::PW_H_B: begin
                    prv_we    = 1'b1;
                    prv_waddr = lfl_pkg::HEAD_IDX;
                    prv_wdata = b_reg;
                end
                default: begin
                end
            endcase
            case (cw.cwr)
                lfl_pkg::CW_INC: begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_inc;
                end
                lfl_pkg::CW_DEC: begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_dec;
                end
                default: begin
                end
            endcase
            case (cw.fwr)
                lfl_pkg::FW_CLR: begin
                    frm_we    = 1'b1;
                    frm_wdata = 1'b0;
                end
                lfl_pkg::FW_SET: begin
                    frm_we    = 1'b1;
                    frm_wdata = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            b_reg <= lfl_pkg::idx_t'(start_id);
        end else if (fire && (cw.latch == lfl_pkg::LT_FIRST)) begin
            b_reg <= next_c;
        end
        if (fire && (cw.latch == lfl_pkg::LT_NP)) begin
            n_reg   <= next_c;
            p_reg   <= prev_c;
            cnt_reg <= cnt_rd;
        end
    end

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg) begin
            clr_idx_next = clr_idx_reg + lfl_pkg::idx_t'(1);
            if (clr_idx_reg == lfl_pkg::HEAD_IDX) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    assign clr_busy = clr_busy_reg;

endmodule

// ----- bench/lfl_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfl_result_checker: request/result scoreboard for the LRU free list
// Watches both channels, keeps a shadow of the links, pin counts and free
// marks, predicts each result and compares it with what the block returns.
// ----------------------------------------------------------------------------
module lfl_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_buffer_id,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_victim_id,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_pin_count,
    output int          fail_count,
    output int          pending
);

    lfl_pkg::idx_t fwd_link [0:lfl_pkg::NUM_BUFFERS];
    lfl_pkg::idx_t back_link[0:lfl_pkg::NUM_BUFFERS];
    logic          is_free  [0:lfl_pkg::NUM_BUFFERS-1];
    lfl_pkg::pin_t pins     [0:lfl_pkg::NUM_BUFFERS-1];

    lfl_pkg::res_t want_q[$];
    int            fails = 0;

    function automatic lfl_pkg::idx_t link_guard(lfl_pkg::idx_t i);
        return (i > lfl_pkg::HEAD_IDX) ? lfl_pkg::HEAD_IDX : i;
    endfunction

    task automatic clear_shadow();
        for (int i = 0; i < lfl_pkg::NUM_BUFFERS; i++) begin
            is_free[i] = 1'b1;
            pins[i]    = '0;
        end
        // order after reset: head, 1, 2, .., N-1, 0, head
        for (int i = 1; i + 1 < lfl_pkg::NUM_BUFFERS; i++) begin
            fwd_link[i]      = lfl_pkg::idx_t'(i + 1);
            back_link[i + 1] = lfl_pkg::idx_t'(i);
        end
        fwd_link[lfl_pkg::HEAD_IDX]        = lfl_pkg::idx_t'(1);
        back_link[1]                       = lfl_pkg::HEAD_IDX;
        fwd_link[lfl_pkg::NUM_BUFFERS - 1] = lfl_pkg::idx_t'(0);
        back_link[0]                       = lfl_pkg::idx_t'(lfl_pkg::NUM_BUFFERS - 1);
        fwd_link[0]                        = lfl_pkg::HEAD_IDX;
        back_link[lfl_pkg::HEAD_IDX]       = lfl_pkg::idx_t'(0);
    endtask

    task automatic unlink_buffer(input lfl_pkg::idx_t b);
        lfl_pkg::idx_t n;
        lfl_pkg::idx_t p;
        n = link_guard(fwd_link[b]);
        p = link_guard(back_link[b]);
        back_link[n] = p;
        fwd_link[p]  = n;
        fwd_link[b]  = lfl_pkg::HEAD_IDX;
        back_link[b] = lfl_pkg::HEAD_IDX;
    endtask

    task automatic append_mru(input lfl_pkg::idx_t b);
        lfl_pkg::idx_t tail;
        tail = link_guard(back_link[lfl_pkg::HEAD_IDX]);
        back_link[b]                 = tail;
        fwd_link[b]                  = lfl_pkg::HEAD_IDX;
        back_link[lfl_pkg::HEAD_IDX] = b;
        fwd_link[tail]               = b;
    endtask

    // apply one request to the shadow and work out the result it gives
    task automatic apply_request(input logic [1:0] act, input logic [7:0] id,
                                 output lfl_pkg::res_t r);
        lfl_pkg::idx_t b;
        lfl_pkg::idx_t first;
        r = '0;
        b = lfl_pkg::idx_t'(id);
        // an 8-bit id is always below NUM_BUFFERS here
        if (act == lfl_pkg::ACT_PIN) begin
            if (pins[id] == lfl_pkg::PIN_MAX) begin
                r.status = lfl_pkg::ST_OVERFLOW;
            end else begin
                if (pins[id] == '0 && is_free[id]) begin
                    unlink_buffer(b);
                    is_free[id] = 1'b0;
                end
                pins[id] = pins[id] + 1'b1;
            end
            r.count = lfl_pkg::cnt_out_t'(pins[id]);
        end else if (act == lfl_pkg::ACT_UNPIN) begin
            if (pins[id] == '0) begin
                r.status = lfl_pkg::ST_UNPIN_ERR;
            end else begin
                pins[id] = pins[id] - 1'b1;
                if (pins[id] == '0) begin
                    append_mru(b);
                    is_free[id] = 1'b1;
                end
            end
            r.count = lfl_pkg::cnt_out_t'(pins[id]);
        end else if (act == lfl_pkg::ACT_TAKE) begin
            first = link_guard(fwd_link[lfl_pkg::HEAD_IDX]);
            if (first == lfl_pkg::HEAD_IDX) begin
                r.status = lfl_pkg::ST_EMPTY;
            end else begin
                unlink_buffer(first);
                is_free[first[lfl_pkg::BUF_W-1:0]] = 1'b0;
                r.victim = lfl_pkg::id_t'(first);
                r.count  = lfl_pkg::cnt_out_t'(pins[first[lfl_pkg::BUF_W-1:0]]);
            end
        end
    endtask

    always @(posedge aclk) begin
        lfl_pkg::res_t want;
        lfl_pkg::res_t next_want;
        if (!aresetn) begin
            clear_shadow();
            want_q.delete();
            pending    <= 0;
            fail_count <= fails;
        end else begin
            // retire first: a result never belongs to the request of the same edge
            if (m_valid && m_ready) begin
                // values shown as victim/status/count
                if (want_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with no request waiting: got %0d/%0d/%0d",
                             $time, m_victim_id, m_status, m_pin_count);
                end else begin
                    want = want_q.pop_front();
                    if (want.victim !== m_victim_id || want.status !== m_status ||
                        want.count !== m_pin_count) begin
                        fails++;
                        $display("%0t: mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, want.victim, want.status, want.count,
                                 m_victim_id, m_status, m_pin_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_request(s_action, s_buffer_id, next_want);
                want_q.push_back(next_want);
            end
            pending    <= want_q.size();
            fail_count <= fails;
        end
    end

endmodule

// ----- bench/tb_lru_free_list_with_pins_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_free_list_with_pins_top: LRU free list with pin counts testbench
// Directed pins, unpins and takes, a full drain, a short pin count climb,
// then random traffic under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_lru_free_list_with_pins_top;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [7:0]  s_buffer_id;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_victim_id;
    logic [1:0]  m_status;
    logic [15:0] m_pin_count;

    int fail_count;
    int pending;

    int send_pct = 0;
    int recv_pct = 0;
    int hold_req = 0;

    lru_free_list_with_pins_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_buffer_id (s_buffer_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_victim_id (m_victim_id),
        .m_status    (m_status),
        .m_pin_count (m_pin_count)
    );

    lfl_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_buffer_id (s_buffer_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_victim_id (m_victim_id),
        .m_status    (m_status),
        .m_pin_count (m_pin_count),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    task automatic send_req(input logic [1:0] act, input logic [7:0] id);
        while ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_buffer_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drop valid and hold until every outstanding result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic send_random_req();
        int          pick;
        logic [7:0]  id;
        // most traffic lands on a small hot set so counts climb and fall
        pick = $urandom_range(99);
        id   = ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
        if (pick < 8)
            send_req(ACT_UNUSED, 8'($urandom_range(255)));
        else if (pick < 28)
            send_req(lfl_pkg::ACT_TAKE, id);
        else if (pick < 64)
            send_req(lfl_pkg::ACT_PIN, id);
        else
            send_req(lfl_pkg::ACT_UNPIN, id);
    endtask

    initial begin
        s_valid     <= 1'b0;
        s_action    <= lfl_pkg::ACT_PIN;
        s_buffer_id <= 8'd0;
        aresetn     <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: unlink, repin, append, errors, take, pin of a taken buffer
        send_req(lfl_pkg::ACT_PIN, 8'd0);
        send_req(lfl_pkg::ACT_PIN, 8'd255);
        send_req(lfl_pkg::ACT_PIN, 8'd0);
        send_req(lfl_pkg::ACT_UNPIN, 8'd0);
        send_req(lfl_pkg::ACT_UNPIN, 8'd0);
        send_req(lfl_pkg::ACT_UNPIN, 8'd0);
        send_req(lfl_pkg::ACT_TAKE, 8'd0);
        send_req(lfl_pkg::ACT_PIN, 8'd1);
        send_req(lfl_pkg::ACT_UNPIN, 8'd1);
        send_req(ACT_UNUSED, 8'hAA);
        send_req(ACT_UNUSED, 8'h55);
        send_req(lfl_pkg::ACT_UNPIN, 8'd255);
        send_req(lfl_pkg::ACT_TAKE, 8'hFF);
        send_req(lfl_pkg::ACT_PIN, 8'd128);
        send_req(lfl_pkg::ACT_PIN, 8'd128);
        send_req(lfl_pkg::ACT_UNPIN, 8'd128);
        send_req(lfl_pkg::ACT_UNPIN, 8'd128);
        send_req(lfl_pkg::ACT_TAKE, 8'd0);
        send_req(lfl_pkg::ACT_UNPIN, 8'd200);
        send_req(lfl_pkg::ACT_PIN, 8'h55);

        // drain the whole list, past empty
        repeat (lfl_pkg::NUM_BUFFERS + 4) send_req(lfl_pkg::ACT_TAKE, 8'd0);
        send_req(lfl_pkg::ACT_PIN, 8'd3);
        send_req(lfl_pkg::ACT_UNPIN, 8'd3);
        send_req(lfl_pkg::ACT_TAKE, 8'd0);
        send_req(lfl_pkg::ACT_TAKE, 8'd0);

        // climb one count a little way, bring it back down and past zero
        repeat (40) send_req(lfl_pkg::ACT_PIN, 8'd7);
        repeat (41) send_req(lfl_pkg::ACT_UNPIN, 8'd7);
        send_req(lfl_pkg::ACT_PIN, 8'd7);
        send_req(lfl_pkg::ACT_PIN, 8'd7);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 48; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 48; end
                default: begin send_pct = 15; recv_pct = 15; end
            endcase
            for (int n = 0; n < 145; n++) begin
                if (phase == 0 && n == 20)
                    hold_req++;
                if (phase == 5 && n == 72)
                    wait_drained();
                send_random_req();
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
